// ----- rtl/core/bpb_pkg.sv -----
// Shared constants for the Bollinger %B core.
// No dependencies; imported by every module of the block but bpb_fifo.
package bpb_pkg;

	localparam int unsigned PRICE_W = 24;
	localparam int unsigned PCT_W = 16;
	localparam int unsigned WINDOW_DEF = 20;

	// Reset value of the band floor register.
	localparam logic [PRICE_W-1:0] BAND_FLOOR_RST = PRICE_W'(1);

	// Neutral result, 0.5 in Q2.14.
	localparam logic [PCT_W-1:0] HALF_Q14 = PCT_W'(8192);

	// Saturation bounds of the Q2.14 result.
	localparam int unsigned PCT_POS_MAX = 32767;
	localparam int unsigned PCT_NEG_MAG = 32768;

	// The divider forms num * 2^FRAC_SH / r and keeps QUO_W quotient bits.
	localparam int unsigned FRAC_SH = 12;
	localparam int unsigned QUO_W = 18;

endpackage

// ----- rtl/core/bollinger_percent_b_core.sv -----
// Top level of the Bollinger %B core: config register, front end, queue, back end.
// Depends on bpb_pkg, bpb_front, bpb_fifo and bpb_back.

// Each price transaction on the slave stream yields exactly one result transaction
// on the master stream: %B of the last WINDOW prices in signed Q2.14 (8192 is 0.5),
// truncated toward zero and saturated, with tuser set once the window is full.
// Before the window fills, or when four standard deviations fall below band_floor,
// the result is 0.5. The front end takes a price every cycle into a two-entry queue,
// except while its last stage holds a price and the queue is full; the back end then
// works on one price at a time, its pace set by the square root that yields one bit
// per cycle followed by an 18-step divider. A narrow band ends right after the root,
// with no division. Prices that arrive before the window is full skip the root and
// the divider. Write band_floor only while no transaction is in flight.
module bollinger_percent_b_core #(
	parameter int unsigned WINDOW = bpb_pkg::WINDOW_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [bpb_pkg::PRICE_W-1:0] cfg_wdata,       // band_floor
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bpb_pkg::PRICE_W-1:0] s_axis_tdata,    // price
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bpb_pkg::PCT_W-1:0]   m_axis_tdata,    // pct_b
	output logic                        m_axis_tuser     // window_full
);
	import bpb_pkg::*;

	localparam int unsigned SUM_W = PRICE_W + $clog2(WINDOW);
	localparam int unsigned SQ_W  = 2 * PRICE_W + $clog2(WINDOW);
	localparam int unsigned ENT_W = PRICE_W + SUM_W + SQ_W + 1;

	logic [PRICE_W-1:0] band_floor_q;

	logic               q_push, q_full, q_pop, q_empty;
	logic [PRICE_W-1:0] push_price, pop_price;
	logic [SUM_W-1:0]   push_sum, pop_sum;
	logic [SQ_W-1:0]    push_sum_sq, pop_sum_sq;
	logic               push_win_full, pop_win_full;
	logic [ENT_W-1:0]   q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_floor_q <= BAND_FLOOR_RST;
		end else if (cfg_we) begin
			band_floor_q <= cfg_wdata;
		end
	end

	bpb_front #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W),
		.SQ_W   (SQ_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.push          (q_push),
		.q_full        (q_full),
		.push_price    (push_price),
		.push_sum      (push_sum),
		.push_sum_sq   (push_sum_sq),
		.push_win_full (push_win_full)
	);

	assign q_wdata = {push_win_full, push_sum_sq, push_sum, push_price};
	assign {pop_win_full, pop_sum_sq, pop_sum, pop_price} = q_rdata;

	bpb_fifo #(
		.DATA_W (ENT_W)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	bpb_back #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W),
		.SQ_W   (SQ_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.band_floor    (band_floor_q),
		.q_empty       (q_empty),
		.pop           (q_pop),
		.q_price       (pop_price),
		.q_sum         (pop_sum),
		.q_sum_sq      (pop_sum_sq),
		.q_win_full    (pop_win_full),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// The front end must never write into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue written while full");

	// The back end must never take an entry from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> !q_empty)
		else $error("queue read while empty");

	// A result from a window that is not yet full is always the neutral value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == HALF_Q14))
		else $error("partial window gave a result other than one half");

endmodule

// ----- rtl/core/bpb_fifo.sv -----
// Two-entry queue between the front and back ends of the %B core.
// Depends on nothing outside this file.
module bpb_fifo #(
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/core/bpb_front.sv -----
// Front end of the %B core: sample ring, squares and running window sums.
// Uses bpb_pkg; feeds the queue that sits in front of bpb_back.
module bpb_front #(
	parameter int unsigned WINDOW = bpb_pkg::WINDOW_DEF,
	parameter int unsigned SUM_W  = bpb_pkg::PRICE_W + $clog2(WINDOW),
	parameter int unsigned SQ_W   = 2 * bpb_pkg::PRICE_W + $clog2(WINDOW)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [bpb_pkg::PRICE_W-1:0] s_axis_tdata,   // price
	output logic                        push,
	input  logic                        q_full,
	output logic [bpb_pkg::PRICE_W-1:0] push_price,
	output logic [SUM_W-1:0]            push_sum,
	output logic [SQ_W-1:0]             push_sum_sq,
	output logic                        push_win_full
);
	import bpb_pkg::*;

	localparam int unsigned SLOT_W = $clog2(WINDOW);
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);

	logic [PRICE_W-1:0]   ring [WINDOW];
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     filled_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sum_sq_q;

	logic                 v_s1, v_s2;
	logic [PRICE_W-1:0]   price_s1, price_s2;
	logic [PRICE_W-1:0]   old_s1;
	logic                 sub_s1, sub_s2;
	logic                 full_s1, full_s2;
	logic [2*PRICE_W-1:0] pp_s2, oo_s2;
	logic [PRICE_W-1:0]   old_s2;

	logic                 advance;
	logic                 accept;
	logic [SUM_W-1:0]     sum_nx;
	logic [SQ_W-1:0]      sum_sq_nx;

	// The whole front pipeline freezes only when its last stage cannot enter the queue.
	assign advance       = !(v_s2 && q_full);
	assign s_axis_tready = advance;
	assign accept        = s_axis_tvalid && advance;
	assign push          = v_s2 && !q_full;

	assign sum_nx    = sum_q + SUM_W'(price_s2) - (sub_s2 ? SUM_W'(old_s2) : '0);
	assign sum_sq_nx = sum_sq_q + SQ_W'(pp_s2) - (sub_s2 ? SQ_W'(oo_s2) : '0);

	assign push_price    = price_s2;
	assign push_sum      = sum_nx;
	assign push_sum_sq   = sum_sq_nx;
	assign push_win_full = full_s2;

	// The read sees the sample that the new one replaces.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring[slot_q] <= s_axis_tdata;
			old_s1       <= ring[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (accept) begin
				price_s1 <= s_axis_tdata;
				sub_s1   <= (filled_q == CNT_W'(WINDOW));
				full_s1  <= (filled_q >= CNT_W'(WINDOW - 1));
			end
			price_s2 <= price_s1;
			old_s2   <= old_s1;
			pp_s2    <= price_s1 * price_s1;
			oo_s2    <= old_s1 * old_s1;
			sub_s2   <= sub_s1;
			full_s2  <= full_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			slot_q   <= '0;
			filled_q <= '0;
			sum_q    <= '0;
			sum_sq_q <= '0;
		end else begin
			if (advance) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
			end
			if (accept) begin
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
				if (filled_q != CNT_W'(WINDOW)) begin
					filled_q <= filled_q + CNT_W'(1);
				end
			end
			if (push) begin
				sum_q    <= sum_nx;
				sum_sq_q <= sum_sq_nx;
			end
		end
	end

endmodule

// ----- rtl/core/bpb_back.sv -----
// Back end of the %B core: variance, bit-serial square root, divider, saturation.
// Uses bpb_pkg; pops items from bpb_fifo and owns the output register.
module bpb_back #(
	parameter int unsigned WINDOW = bpb_pkg::WINDOW_DEF,
	parameter int unsigned SUM_W  = bpb_pkg::PRICE_W + $clog2(WINDOW),
	parameter int unsigned SQ_W   = 2 * bpb_pkg::PRICE_W + $clog2(WINDOW)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bpb_pkg::PRICE_W-1:0] band_floor,
	input  logic                        q_empty,
	output logic                        pop,
	input  logic [bpb_pkg::PRICE_W-1:0] q_price,
	input  logic [SUM_W-1:0]            q_sum,
	input  logic [SQ_W-1:0]             q_sum_sq,
	input  logic                        q_win_full,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [bpb_pkg::PCT_W-1:0]   m_axis_tdata,   // pct_b
	output logic                        m_axis_tuser    // window_full
);
	import bpb_pkg::*;

	localparam int unsigned R_W    = SUM_W;
	localparam int unsigned D_W    = 2 * R_W;
	localparam int unsigned NUM_W  = SUM_W + 3;
	localparam int unsigned MAG_W  = SUM_W + 2;
	localparam int unsigned PRE_SH = QUO_W - FRAC_SH;
	localparam int unsigned STEP_W = $clog2((R_W > QUO_W) ? R_W : QUO_W);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP1,
		S_PREP2,
		S_ROOT,
		S_CHECK,
		S_DIV0,
		S_DIV,
		S_SAT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [PRICE_W-1:0] price_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sum_sq_q;
	logic [D_W-1:0]     nq_q, ss_q;
	logic [SUM_W-1:0]   nlast_q, floorn_q;
	logic [D_W-1:0]     dsh_q;
	logic [R_W+1:0]     rem_q;
	logic [R_W-1:0]     root_q;
	logic [STEP_W-1:0]  step_q;
	logic               neg_q;
	logic [R_W:0]       drem_q;
	logic [QUO_W-1:0]   dq_q;
	logic [PCT_W-1:0]   res_q;
	logic               win_q;
	logic               out_valid_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic               out_win_q;

	logic [R_W+1:0]     rt_cur, rt_trial;
	logic               rt_ge;
	logic               band_narrow;
	logic signed [NUM_W-1:0] num;
	logic [NUM_W-1:0]   num_abs;
	logic [MAG_W-1:0]   mag;
	logic [R_W:0]       dv_cur;
	logic               dv_ge;
	logic               out_free;

	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_pct_q;
	assign m_axis_tuser  = out_win_q;

	// One root bit per step: bring down two radicand bits, try 4*root + 1.
	assign rt_cur   = {rem_q[R_W-1:0], dsh_q[D_W-1 -: 2]};
	assign rt_trial = {root_q, 2'b01};
	assign rt_ge    = (rt_cur >= rt_trial);

	// Band test done exactly as 4*r < band_floor*WINDOW, or a zero root.
	assign band_narrow = ({root_q, 2'b00} < (R_W + 2)'(floorn_q)) || (root_q == '0);

	assign num = $signed({3'b000, nlast_q}) - $signed({3'b000, sum_q})
		+ $signed({2'b00, root_q, 1'b0});
	assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign mag     = num_abs[MAG_W-1:0];

	assign dv_cur = {drem_q[R_W-1:0], dq_q[QUO_W-1]};
	assign dv_ge  = (dv_cur >= {1'b0, root_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_pct_q   <= '0;
			out_win_q   <= 1'b0;
			price_q     <= '0;
			sum_q       <= '0;
			sum_sq_q    <= '0;
			nq_q        <= '0;
			ss_q        <= '0;
			nlast_q     <= '0;
			floorn_q    <= '0;
			dsh_q       <= '0;
			rem_q       <= '0;
			root_q      <= '0;
			step_q      <= '0;
			neg_q       <= 1'b0;
			drem_q      <= '0;
			dq_q        <= '0;
			res_q       <= '0;
			win_q       <= 1'b0;
		end else begin
			// In S_DONE the output register is reloaded below instead.
			if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						price_q  <= q_price;
						sum_q    <= q_sum;
						sum_sq_q <= q_sum_sq;
						win_q    <= q_win_full;
						if (q_win_full) begin
							state_q <= S_PREP1;
						end else begin
							res_q   <= HALF_Q14;
							state_q <= S_DONE;
						end
					end
				end
				S_PREP1: begin
					nq_q     <= D_W'(sum_sq_q) * D_W'(WINDOW);
					ss_q     <= D_W'(sum_q) * D_W'(sum_q);
					nlast_q  <= SUM_W'(price_q) * SUM_W'(WINDOW);
					floorn_q <= SUM_W'(band_floor) * SUM_W'(WINDOW);
					state_q  <= S_PREP2;
				end
				S_PREP2: begin
					dsh_q   <= nq_q - ss_q;
					rem_q   <= '0;
					root_q  <= '0;
					step_q  <= '0;
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rem_q  <= rt_ge ? rt_cur - rt_trial : rt_cur;
					root_q <= {root_q[R_W-2:0], rt_ge};
					dsh_q  <= {dsh_q[D_W-3:0], 2'b00};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(R_W - 1)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (band_narrow) begin
						res_q   <= HALF_Q14;
						state_q <= S_DONE;
					end else begin
						neg_q   <= num[NUM_W-1];
						drem_q  <= (R_W + 1)'(mag[MAG_W-1:PRE_SH]);
						dq_q    <= {mag[PRE_SH-1:0], {FRAC_SH{1'b0}}};
						state_q <= S_DIV0;
					end
				end
				S_DIV0: begin
					// A quotient that needs more than QUO_W bits saturates directly.
					if (drem_q >= {1'b0, root_q}) begin
						res_q   <= neg_q ? {1'b1, {(PCT_W-1){1'b0}}} : PCT_W'(PCT_POS_MAX);
						state_q <= S_DONE;
					end else begin
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					drem_q <= dv_ge ? dv_cur - {1'b0, root_q} : dv_cur;
					dq_q   <= {dq_q[QUO_W-2:0], dv_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QUO_W - 1)) begin
						state_q <= S_SAT;
					end
				end
				S_SAT: begin
					if (neg_q) begin
						if (dq_q > QUO_W'(PCT_NEG_MAG)) begin
							res_q <= {1'b1, {(PCT_W-1){1'b0}}};
						end else begin
							res_q <= PCT_W'(QUO_W'(-dq_q));
						end
					end else begin
						if (dq_q > QUO_W'(PCT_POS_MAX)) begin
							res_q <= PCT_W'(PCT_POS_MAX);
						end else begin
							res_q <= dq_q[PCT_W-1:0];
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_pct_q   <= res_q;
						out_win_q   <= win_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sim/bollinger_percent_b_core_tb.sv -----
// Self-checking testbench for bollinger_percent_b_core: price stream in, %B stream out.
// Depends on bpb_pkg and the core RTL; a built-in window predictor scores every result not typed in the directed table.
module bollinger_percent_b_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpb_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int WIN = WINDOW_DEF;
	localparam int SETTLE_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS [PHASES] = '{260, 120, 260, 220, 200, 170};
	localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
	localparam int DIRECTED_N = 24;

	typedef enum {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;
	typedef enum {RUN_WIDE, RUN_FLAT, RUN_JITTER, RUN_TREND, RUN_EXTREME} run_kind_t;

	typedef struct packed {
		logic signed [PCT_W-1:0] pct;
		logic                    full;
	} pct_result_t;

	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic               typed;
		pct_result_t        want;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [PRICE_W-1:0]  cfg_wdata;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [PRICE_W-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [PCT_W-1:0]    m_axis_tdata;
	logic                m_axis_tuser;

	bollinger_percent_b_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Opening window of alternating extremes. The first WIN-1 results are neutral
	// by construction; the rest are scored by the predictor.
	directed_row_t directed_rows [DIRECTED_N] = '{
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'h000000, 1'b1, '{HALF_Q14, 1'b0}},
		'{24'hFFFFFF, 1'b0, '0},
		'{24'hFFFFFF, 1'b0, '0},
		'{24'h000000, 1'b0, '0},
		'{24'h800000, 1'b0, '0},
		'{24'h000001, 1'b0, '0}
	};

	// Window predictor state.
	logic [PRICE_W-1:0] hist [WIN];
	int unsigned        hist_slot;
	int unsigned        hist_count;
	longint unsigned    win_sum;
	longint unsigned    win_sum_sq;
	logic [PRICE_W-1:0] floor_model;

	pct_result_t expected_pct_q [$];

	idle_mode_t idle_mode;
	run_kind_t  run_kind;
	int         run_left;
	longint     run_base;
	int         run_step;

	int n_errors;
	int n_prices;
	int n_results;
	int n_filling;
	int n_divided;
	int n_narrow;
	int n_flat;
	int idle_cycles;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned acc;
		longint unsigned trial;
		acc = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = acc | (64'd1 << b);
			if (trial * trial <= v) begin
				acc = trial;
			end
		end
		return acc;
	endfunction

	// Pushes one price into the window and returns the %B it should produce.
	function automatic pct_result_t advance_window(input logic [PRICE_W-1:0] price);
		longint unsigned p64;
		longint unsigned old;
		longint unsigned spread;
		longint unsigned root;
		longint          num;
		longint          q;
		pct_result_t     res;
		p64 = price;
		if (hist_count >= WIN) begin
			old = hist[hist_slot];
			win_sum -= old;
			win_sum_sq -= old * old;
		end
		hist[hist_slot] = price;
		win_sum += p64;
		win_sum_sq += p64 * p64;
		hist_slot = (hist_slot + 1) % WIN;
		if (hist_count < WIN) begin
			hist_count++;
		end
		res.full = (hist_count >= WIN);
		res.pct = HALF_Q14;
		if (!res.full) begin
			n_filling++;
		end else begin
			spread = longint'(WIN) * win_sum_sq - win_sum * win_sum;
			root = root_floor(spread);
			if (root == 0) begin
				n_flat++;
			end else if (root * 4 < longint'(floor_model) * WIN) begin
				n_narrow++;
			end else begin
				// (n*last - S + 2r) / 4r in Q2.14 reduces to num * 4096 / r.
				num = longint'(WIN) * longint'(p64) - longint'(win_sum) + 2 * longint'(root);
				q = (num * 4096) / longint'(root);
				if (q > 32767) begin
					q = 32767;
				end
				if (q < -32768) begin
					q = -32768;
				end
				res.pct = q[PCT_W-1:0];
				n_divided++;
			end
		end
		return res;
	endfunction

	// Prices come in runs of one shape so that windows go flat, narrow and wide.
	function automatic logic [PRICE_W-1:0] next_price();
		int     pick;
		longint v;
		if (run_left == 0) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				run_kind = RUN_FLAT;
			end else if (pick < 45) begin
				run_kind = RUN_JITTER;
			end else if (pick < 65) begin
				run_kind = RUN_TREND;
			end else if (pick < 85) begin
				run_kind = RUN_WIDE;
			end else begin
				run_kind = RUN_EXTREME;
			end
			run_left = (run_kind == RUN_FLAT) ? $urandom_range(20, 45) : $urandom_range(4, 40);
			run_base = $urandom_range(0, PRICE_MAX);
			run_step = int'($urandom_range(0, 40000)) - 20000;
		end
		run_left--;
		case (run_kind)
			RUN_FLAT: begin
				v = run_base;
			end
			RUN_JITTER: begin
				v = run_base + $urandom_range(0, 3);
			end
			RUN_TREND: begin
				run_base += run_step;
				v = run_base;
			end
			RUN_WIDE: begin
				v = $urandom_range(0, PRICE_MAX);
			end
			default: begin
				v = $urandom_range(1) ? PRICE_MAX : 0;
			end
		endcase
		if (v < 0) begin
			v = 0;
		end
		if (v > PRICE_MAX) begin
			v = PRICE_MAX;
		end
		if (run_kind == RUN_TREND) begin
			run_base = v;
		end
		return v[PRICE_W-1:0];
	endfunction

	function automatic int gap_odds();
		case (idle_mode)
			IDLE_SRC:  return 54;
			IDLE_BOTH: return 37;
			default:   return 0;
		endcase
	endfunction

	function automatic int stall_odds();
		case (idle_mode)
			IDLE_SINK: return 54;
			IDLE_BOTH: return 37;
			default:   return 0;
		endcase
	endfunction

	function automatic logic [PRICE_W-1:0] floor_for_phase(input int ph);
		case (ph)
			0:       return '0;
			1:       return PRICE_MAX;
			2:       return BAND_FLOOR_RST;
			3:       return PRICE_W'($urandom_range(2, 4000));
			4:       return '0;
			default: return PRICE_W'($urandom_range(0, PRICE_MAX));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	// Called just after a rising edge; returns in the time step of acceptance.
	task automatic send_price(input logic [PRICE_W-1:0] price, input logic typed,
			input pct_result_t typed_want);
		int          odds;
		pct_result_t want;
		odds = gap_odds();
		while (odds != 0 && $urandom_range(99) < odds) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= price;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		n_prices++;
		want = advance_window(price);
		if (typed) begin
			want = typed_want;
		end
		expected_pct_q.push_back(want);
	endtask

	task automatic drain_results(input logic settle);
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_pct_q.size() != 0);
		if (settle) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
		end
	endtask

	task automatic set_band_floor(input logic [PRICE_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		floor_model = value;
	endtask

	always @(posedge clk) begin
		if (stall_odds() != 0) begin
			m_axis_tready <= ($urandom_range(99) >= stall_odds());
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		pct_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (expected_pct_q.size() == 0) begin
				report_mismatch("unexpected result transaction, pct_b", $signed(m_axis_tdata), 0);
			end else begin
				want = expected_pct_q.pop_front();
				if (m_axis_tdata !== want.pct) begin
					report_mismatch("pct_b", $signed(m_axis_tdata), want.pct);
				end
				if (m_axis_tuser !== want.full) begin
					report_mismatch("window_full", m_axis_tuser, want.full);
				end
			end
		end
	end

	// Ends the run if neither stream moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : stimulus
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		idle_mode = IDLE_NONE;
		hist_slot = 0;
		hist_count = 0;
		win_sum = 0;
		win_sum_sq = 0;
		floor_model = BAND_FLOOR_RST;
		run_kind = RUN_WIDE;
		run_left = 0;
		run_base = 0;
		run_step = 0;
		n_errors = 0;
		n_prices = 0;
		n_results = 0;
		n_filling = 0;
		n_divided = 0;
		n_narrow = 0;
		n_flat = 0;
		idle_cycles = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIRECTED_N; r++) begin
			send_price(directed_rows[r].price, directed_rows[r].typed, directed_rows[r].want);
		end
		drain_results(1'b1);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_mode = idle_mode_t'(ph % 4);
			set_band_floor(floor_for_phase(ph));
			for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
				// Hold the sender off once mid-phase until the result stream is empty.
				if (ph == 3 && i == PHASE_ITEMS[ph] / 2) begin
					drain_results(1'b0);
				end
				send_price(next_price(), 1'b0, '0);
			end
			drain_results(1'b1);
		end

		if (expected_pct_q.size() != 0) begin
			report_mismatch("results never delivered", expected_pct_q.size(), 0);
		end
		$display("Ran %0d prices (%0d results) over %0d band_floor settings and four idle patterns.",
			n_prices, n_results, PHASES);
		$display("Windows: %0d filling, %0d flat, %0d narrow band, %0d divided; %0d errors.",
			n_filling, n_flat, n_narrow, n_divided, n_errors);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
